// ===== src/pkgate_pkg.sv =====
// Shared types, constants and helper functions for the port knock gate.
// Used by pkgate_csr, pkgate_core and port_knock_gate; depends on nothing.
package pkgate_pkg;

   // Sequence limits.
   localparam int MaxKnocks  = 8;
   localparam int PortWidth  = 16;
   localparam int TickWidth  = 32;
   localparam int ProgWidth  = 4;
   localparam int KnockIdxW  = 3;

   // Register map: register index is paddr[5:3], byte address 8 * index.
   localparam int AddrWidth  = 6;
   localparam int DataWidth  = 64;
   localparam logic [2:0] RegProtectedPort  = 3'd0;
   localparam logic [2:0] RegTimeoutTicks   = 3'd1;
   localparam logic [2:0] RegSequenceLength = 3'd2;
   localparam logic [2:0] RegKnockPortsLow  = 3'd3;
   localparam logic [2:0] RegKnockPortsHigh = 3'd4;

   // Reset values of the registers.
   localparam logic [15:0] ProtectedPortReset  = 16'd9090;
   localparam logic [31:0] TimeoutTicksReset   = 32'd10000;
   localparam logic [3:0]  SequenceLengthReset = 4'd3;
   localparam logic [63:0] KnockPortsLowReset  = 64'd19087117845714;
   localparam logic [63:0] KnockPortsHighReset = 64'd0;

   // Configuration as seen by the filter core.
   typedef struct packed {
      logic [15:0] protected_port;
      logic [31:0] timeout_ticks;
      logic [3:0]  sequence_length;
      logic [63:0] knock_ports_low;
      logic [63:0] knock_ports_high;
   } cfg_type;

   // Filter state carried from one item to the next.
   typedef struct packed {
      logic        open_flag;
      logic [3:0]  progress;
      logic [31:0] last_time;
   } knock_state_type;

   // Length register clamped to 1..MaxKnocks.
   function automatic logic [3:0] effective_length(input logic [3:0] len);
      logic [3:0] n;
      n = len;
      if (n == 4'd0) begin
         n = 4'd1;
      end else if (n > 4'(MaxKnocks)) begin
         n = 4'(MaxKnocks);
      end
      return n;
   endfunction

   // Selects the 16-bit knock port at a given position of the sequence.
   function automatic logic [15:0] knock_port_at(input logic [63:0] low,
                                                 input logic [63:0] high,
                                                 input logic [2:0]  idx);
      logic [63:0] word;
      word = idx[2] ? high : low;
      return word[{idx[1:0], 4'd0} +: 16];
   endfunction

endpackage

// ===== src/pkgate_csr.sv =====
// Configuration register file of the port knock gate, APB-style access.
// Depends on pkgate_pkg for the register map, reset values and cfg_type.
module pkgate_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pkgate_pkg::AddrWidth-1:0]    paddr,
   input  logic [pkgate_pkg::DataWidth-1:0]    pwdata,
   output logic [pkgate_pkg::DataWidth-1:0]    prdata,
   output logic                                pready,
   output pkgate_pkg::cfg_type                 cfg
);

   pkgate_pkg::cfg_type cfg_ff;
   logic [2:0]          reg_idx;
   logic                wr_en;

   assign reg_idx = paddr[5:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protected_port   <= pkgate_pkg::ProtectedPortReset;
         cfg_ff.timeout_ticks    <= pkgate_pkg::TimeoutTicksReset;
         cfg_ff.sequence_length  <= pkgate_pkg::SequenceLengthReset;
         cfg_ff.knock_ports_low  <= pkgate_pkg::KnockPortsLowReset;
         cfg_ff.knock_ports_high <= pkgate_pkg::KnockPortsHighReset;
      end else if (wr_en) begin
         unique case (reg_idx)
            pkgate_pkg::RegProtectedPort:  cfg_ff.protected_port   <= pwdata[15:0];
            pkgate_pkg::RegTimeoutTicks:   cfg_ff.timeout_ticks    <= pwdata[31:0];
            pkgate_pkg::RegSequenceLength: cfg_ff.sequence_length  <= pwdata[3:0];
            pkgate_pkg::RegKnockPortsLow:  cfg_ff.knock_ports_low  <= pwdata;
            pkgate_pkg::RegKnockPortsHigh: cfg_ff.knock_ports_high <= pwdata;
            default: begin
            end
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_idx)
         pkgate_pkg::RegProtectedPort:  prdata = {48'd0, cfg_ff.protected_port};
         pkgate_pkg::RegTimeoutTicks:   prdata = {32'd0, cfg_ff.timeout_ticks};
         pkgate_pkg::RegSequenceLength: prdata = {60'd0, cfg_ff.sequence_length};
         pkgate_pkg::RegKnockPortsLow:  prdata = cfg_ff.knock_ports_low;
         pkgate_pkg::RegKnockPortsHigh: prdata = cfg_ff.knock_ports_high;
         default:                       prdata = '0;
      endcase
   end

endmodule

// ===== src/pkgate_core.sv =====
// Knock filter datapath: input register, state update and result register.
// Depends on pkgate_pkg for cfg_type, knock_state_type and helper functions.
module pkgate_core (
   input  logic                  clock,
   input  logic                  reset,
   input  pkgate_pkg::cfg_type   cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_dest_port,
   input  logic [31:0]           req_now_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accept,
   output logic                  rsp_gate_open,
   output logic [3:0]            rsp_knock_progress
);

   // Input register.
   logic        in_valid_ff;
   logic [15:0] in_port_ff;
   logic [31:0] in_now_ff;

   // Filter state and result register.
   pkgate_pkg::knock_state_type state_ff, state_in;
   logic        out_valid_ff;
   logic        out_accept_ff, out_accept_in;

   logic        advance;
   logic        load;
   logic [3:0]  eff_len;
   logic [31:0] elapsed;
   logic        timed_out;
   pkgate_pkg::knock_state_type cleared;
   logic        match;

   // The result register frees up when empty or when its item is taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   // Timeout check, then match against the next expected knock port.
   always_comb begin
      eff_len   = pkgate_pkg::effective_length(cfg.sequence_length);
      elapsed   = in_now_ff - state_ff.last_time;
      timed_out = elapsed > cfg.timeout_ticks;
      cleared   = state_ff;
      if (timed_out) begin
         cleared.open_flag = 1'b0;
         cleared.progress  = 4'd0;
         cleared.last_time = 32'd0;
      end
      match = (cleared.progress < eff_len) &&
              (in_port_ff == pkgate_pkg::knock_port_at(cfg.knock_ports_low,
                                                      cfg.knock_ports_high,
                                                      cleared.progress[2:0]));
      state_in = cleared;
      if (match) begin
         state_in.last_time = in_now_ff;
         state_in.progress  = cleared.progress + 4'd1;
         if (cleared.progress + 4'd1 == eff_len) begin
            state_in.open_flag = 1'b1;
         end
      end
      out_accept_in = 1'b1;
      // The protected port leaves the state untouched.
      if (in_port_ff == cfg.protected_port) begin
         state_in      = state_ff;
         out_accept_in = state_ff.open_flag;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.open_flag <= 1'b0;
         state_ff.progress  <= 4'd0;
         state_ff.last_time <= 32'd0;
      end else begin
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            in_valid_ff  <= load;
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end else if (load) begin
            in_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         in_port_ff <= req_dest_port;
         in_now_ff  <= req_now_ticks;
      end
      if (advance && in_valid_ff) begin
         out_accept_ff <= out_accept_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_accept         = out_accept_ff;
   assign rsp_gate_open      = state_ff.open_flag;
   assign rsp_knock_progress = state_ff.progress;

endmodule

// ===== src/port_knock_gate.sv =====
// Top level of the port knock gate: register file plus knock filter core.
// Depends on pkgate_pkg, pkgate_csr and pkgate_core.
//
// Usage: each item on the req_ channel carries a packet's destination port
// and the current tick count. Every item yields exactly one rsp_ item with
// the pass/drop decision, the open flag and the knock progress after it.
// Packets to the protected port pass only while the gate is open; other
// packets always pass and are checked as knocks after a timeout test.
// An item accepted into the input register moves on to the result register,
// which drives rsp_valid, as soon as that register is empty or its item is
// taken. Throughput is one item per cycle while the receiver does not hold
// rsp_stall, set by the single state update between the two registers.
// When the receiver holds rsp_stall, the result register keeps its item and
// one more item waits in the input register; after that req_stall rises.
// Reset clears both pipeline stages, closes the gate, zeroes progress and
// the knock timestamp, and loads the register reset values.
// Registers sit at byte address 8 * index on the APB-style port; write them
// only while no item is in flight.
module port_knock_gate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_dest_port,
   input  logic [31:0]                         req_now_ticks,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accept,
   output logic                                rsp_gate_open,
   output logic [3:0]                          rsp_knock_progress,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pkgate_pkg::AddrWidth-1:0]    paddr,
   input  logic [pkgate_pkg::DataWidth-1:0]    pwdata,
   output logic [pkgate_pkg::DataWidth-1:0]    prdata,
   output logic                                pready
);

   pkgate_pkg::cfg_type cfg;

   // Configuration registers.
   pkgate_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Knock filter.
   pkgate_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dest_port      (req_dest_port),
      .req_now_ticks      (req_now_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accept         (rsp_accept),
      .rsp_gate_open      (rsp_gate_open),
      .rsp_knock_progress (rsp_knock_progress)
   );

endmodule

// ===== test/knock_gate_monitor.sv =====
// Checker for the port knock gate: watches the packet, result and register ports,
// predicts every result item and compares it with what the block returns.
// Depends on pkgate_pkg for the register indexes, reset values and sizes.
`timescale 1ns / 1ps

module knock_gate_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [15:0]                         req_dest_port,
   input  logic [31:0]                         req_now_ticks,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_accept,
   input  logic                                rsp_gate_open,
   input  logic [3:0]                          rsp_knock_progress,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [pkgate_pkg::AddrWidth-1:0]    paddr,
   input  logic [pkgate_pkg::DataWidth-1:0]    pwdata,
   output int                                  error_count,
   output int                                  results_due
);

   typedef struct packed {
      logic       admit;
      logic       gate_open;
      logic [3:0] progress;
   } verdict_type;

   // Register copies as last written on the configuration port.
   logic [15:0] guard_port;
   logic [31:0] timeout_limit;
   logic [3:0]  length_reg;
   logic [15:0] knock_list [pkgate_pkg::MaxKnocks];

   // Filter state carried from one packet to the next.
   logic        gate_state;
   logic [3:0]  knock_count;
   logic [31:0] knock_stamp;

   verdict_type verdict_fifo [$];
   int          errors = 0;

   // Applies one register write to the local copies.
   function automatic void store_register(input logic [2:0] idx, input logic [63:0] value);
      case (idx)
         pkgate_pkg::RegProtectedPort:  guard_port = value[15:0];
         pkgate_pkg::RegTimeoutTicks:   timeout_limit = value[31:0];
         pkgate_pkg::RegSequenceLength: length_reg = value[3:0];
         pkgate_pkg::RegKnockPortsLow: begin
            for (int i = 0; i < 4; i++) knock_list[i] = value[16*i +: 16];
         end
         pkgate_pkg::RegKnockPortsHigh: begin
            for (int i = 0; i < 4; i++) knock_list[4+i] = value[16*i +: 16];
         end
         default: ;
      endcase
   endfunction

   // Works out the decision for one packet and advances the filter state.
   function automatic verdict_type filter_packet(input logic [15:0] port,
                                                 input logic [31:0] now);
      verdict_type v;
      logic [3:0]  span;
      logic [31:0] elapsed;
      v.admit = 1'b1;
      if (port == guard_port) begin
         // The guarded port never counts as a knock and never sees the timeout.
         v.admit = gate_state;
      end else begin
         if (length_reg == 4'd0) span = 4'd1;
         else if (length_reg > 4'(pkgate_pkg::MaxKnocks)) span = 4'(pkgate_pkg::MaxKnocks);
         else span = length_reg;
         // Wrapping difference against the time of the last good knock.
         elapsed = now - knock_stamp;
         if (elapsed > timeout_limit) begin
            gate_state = 1'b0;
            knock_count = 4'd0;
            knock_stamp = 32'd0;
         end
         // A knock only counts while the sequence is still incomplete.
         if (knock_count < span && port == knock_list[knock_count[2:0]]) begin
            knock_stamp = now;
            knock_count = knock_count + 4'd1;
            if (knock_count == span) gate_state = 1'b1;
         end
      end
      v.gate_open = gate_state;
      v.progress = knock_count;
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type seen;
      verdict_type want;
      if (reset) begin
         store_register(pkgate_pkg::RegProtectedPort, 64'(pkgate_pkg::ProtectedPortReset));
         store_register(pkgate_pkg::RegTimeoutTicks, 64'(pkgate_pkg::TimeoutTicksReset));
         store_register(pkgate_pkg::RegSequenceLength,
                        64'(pkgate_pkg::SequenceLengthReset));
         store_register(pkgate_pkg::RegKnockPortsLow, pkgate_pkg::KnockPortsLowReset);
         store_register(pkgate_pkg::RegKnockPortsHigh, pkgate_pkg::KnockPortsHighReset);
         gate_state = 1'b0;
         knock_count = 4'd0;
         knock_stamp = 32'd0;
         verdict_fifo.delete();
      end else begin
         // Results are checked before the new packet is predicted, so a result
         // can never be matched against the packet accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_accept, rsp_gate_open, rsp_knock_progress};
            if (verdict_fifo.size() == 0) begin
               $error("result item arrived with no expected result waiting");
               errors++;
            end else begin
               want = verdict_fifo.pop_front();
               if (seen.admit !== want.admit) begin
                  $error("accept: expected %0d, got %0d", want.admit, seen.admit);
                  errors++;
               end
               if (seen.gate_open !== want.gate_open) begin
                  $error("gate_open: expected %0d, got %0d", want.gate_open, seen.gate_open);
                  errors++;
               end
               if (seen.progress !== want.progress) begin
                  $error("knock_progress: expected %0d, got %0d", want.progress, seen.progress);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            verdict_fifo.push_back(filter_packet(req_dest_port, req_now_ticks));
         end
         if (psel && penable && pwrite && pready) begin
            store_register(paddr[pkgate_pkg::AddrWidth-1:3], pwdata);
         end
      end
      results_due <= verdict_fifo.size();
      error_count <= errors;
   end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the port knock gate: clock, reset, packet and register
// stimulus, and the final verdict. Depends on pkgate_pkg, port_knock_gate and
// knock_gate_monitor, which predicts and checks every result item.
`timescale 1ns / 1ps

module tb_top;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [15:0]                         req_dest_port;
   logic [31:0]                         req_now_ticks;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_accept;
   logic                                rsp_gate_open;
   logic [3:0]                          rsp_knock_progress;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [pkgate_pkg::AddrWidth-1:0]    paddr;
   logic [pkgate_pkg::DataWidth-1:0]    pwdata;
   logic [pkgate_pkg::DataWidth-1:0]    prdata;
   logic                                pready;

   int mismatch_total;
   int results_due;

   // Knobs shared between the stimulus and the result-side process.
   logic tx_calm;
   logic rx_calm;
   logic rx_hold_req;

   // Stimulus-side view of the configuration and of the tick counter.
   logic [15:0] cur_guard;
   logic [31:0] cur_timeout;
   logic [3:0]  cur_length;
   logic [15:0] stage_port [pkgate_pkg::MaxKnocks];
   logic [31:0] tick_now;

   always #1 clock = ~clock;

   port_knock_gate dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dest_port      (req_dest_port),
      .req_now_ticks      (req_now_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accept         (rsp_accept),
      .rsp_gate_open      (rsp_gate_open),
      .rsp_knock_progress (rsp_knock_progress),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   knock_gate_monitor gate_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dest_port      (req_dest_port),
      .req_now_ticks      (req_now_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accept         (rsp_accept),
      .rsp_gate_open      (rsp_gate_open),
      .rsp_knock_progress (rsp_knock_progress),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .pready             (pready),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .error_count        (mismatch_total),
      .results_due        (results_due)
   );

   // Idle stretch length: mostly short, now and then long.
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // Random 16-bit port number.
   function automatic logic [15:0] any_port();
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // Offers one packet after an optional gap and waits until it is taken.
   task automatic send_packet(input logic [15:0] port, input logic [31:0] ticks);
      int gap;
      gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_span();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_dest_port <= port;
      req_now_ticks <= ticks;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering packets and waits until every result item has come back.
   task automatic settle_gate();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register write: setup cycle, then access cycle.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_stage_ports(input logic [63:0] lo, input logic [63:0] hi);
      for (int i = 0; i < 4; i++) begin
         stage_port[i] = lo[16*i +: 16];
         stage_port[4+i] = hi[16*i +: 16];
      end
   endtask

   // Rewrites every register once the block has gone quiet.
   task automatic apply_settings(input logic [15:0] guard, input logic [31:0] limit,
                                 input logic [3:0] length, input logic [63:0] lo,
                                 input logic [63:0] hi);
      settle_gate();
      csr_write(pkgate_pkg::RegProtectedPort, 64'(guard));
      csr_write(pkgate_pkg::RegTimeoutTicks, 64'(limit));
      csr_write(pkgate_pkg::RegSequenceLength, 64'(length));
      csr_write(pkgate_pkg::RegKnockPortsLow, lo);
      csr_write(pkgate_pkg::RegKnockPortsHigh, hi);
      cur_guard = guard;
      cur_timeout = limit;
      cur_length = length;
      load_stage_ports(lo, hi);
   endtask

   // Random traffic: mostly complete knock runs, the rest stray packets.
   task automatic run_phase(input int budget);
      int          sent;
      int          stop;
      logic [3:0]  span;
      logic [31:0] step;
      if (cur_length == 4'd0) span = 4'd1;
      else if (cur_length > 4'(pkgate_pkg::MaxKnocks)) span = 4'(pkgate_pkg::MaxKnocks);
      else span = cur_length;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 3) != 0) begin
            // Let the previous attempt expire so the run starts from scratch.
            if (cur_timeout != 32'hFFFF_FFFF) begin
               tick_now = tick_now + cur_timeout + 32'd1 + $urandom_range(0, 50);
            end
            stop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span - 1) : span;
            for (int k = 0; k < stop; k++) begin
               if ($urandom_range(0, 5) == 0) begin
                  send_packet(any_port(), tick_now);
                  sent++;
               end
               case ($urandom_range(0, 11))
                  0: step = cur_timeout;
                  1: step = cur_timeout + 32'd1;
                  default: step = (cur_timeout < 2000) ? $urandom_range(0, cur_timeout)
                                                       : $urandom_range(0, 2000);
               endcase
               tick_now = tick_now + step;
               send_packet(stage_port[k], tick_now);
               sent++;
            end
            repeat ($urandom_range(1, 3)) begin
               send_packet(cur_guard, tick_now);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 4))
                  0, 1: begin
                     tick_now = tick_now + $urandom_range(0, 100);
                     send_packet(any_port(), tick_now);
                  end
                  2: begin
                     tick_now = tick_now + $urandom_range(0, 100);
                     send_packet(cur_guard, tick_now);
                  end
                  3: begin
                     tick_now = $urandom;
                     send_packet(any_port(), tick_now);
                  end
                  default: send_packet(stage_port[3'($urandom_range(0, 7))], tick_now);
               endcase
               sent++;
            end
         end
      end
   endtask

   // Result side: random stalls, calm stretches, and one long hold on request.
   initial begin : result_side
      int   run;
      logic level;
      wait (reset === 1'b0);
      forever begin
         if (rx_hold_req) begin
            level = 1'b1;
            run = $urandom_range(60, 90);
            rx_hold_req = 1'b0;
         end else if (rx_calm) begin
            level = 1'b0;
            run = 1;
         end else begin
            level = ($urandom_range(0, 99) < 30);
            run = level ? idle_span() : $urandom_range(1, 12);
         end
         @(negedge clock);
         rsp_stall <= level;
         repeat (run - 1) @(negedge clock);
      end
   end

   // Hard limit on the run time.
   initial begin : watchdog
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] lo;
      logic [63:0] hi;
      logic [15:0] guard;
      reset = 1'b1;
      req_valid = 1'b0;
      req_dest_port = '0;
      req_now_ticks = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      rx_hold_req = 1'b0;
      cur_guard = pkgate_pkg::ProtectedPortReset;
      cur_timeout = pkgate_pkg::TimeoutTicksReset;
      cur_length = pkgate_pkg::SequenceLengthReset;
      load_stage_ports(pkgate_pkg::KnockPortsLowReset, pkgate_pkg::KnockPortsHighReset);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed checks on the reset configuration.
      send_packet(cur_guard, 32'd0);                         // closed gate drops
      send_packet(16'h0000, 32'd0);                          // timestamp still zero
      send_packet(stage_port[0], 32'd100);
      send_packet(16'hFFFF, 32'd150);                        // wrong knock keeps progress
      send_packet(stage_port[0], 32'd200);                   // repeated first knock is wrong
      send_packet(stage_port[1], 32'd300);
      send_packet(cur_guard, 32'd350);
      send_packet(stage_port[2], 32'd400);                   // sequence complete, gate opens
      send_packet(cur_guard, 32'hFFFF_FFFF);                 // guarded port skips the timeout
      send_packet(stage_port[0], 32'd500);                   // complete: nothing matches
      send_packet(16'h0001, 32'd400 + cur_timeout);          // exactly at the limit
      send_packet(16'h0001, 32'd401 + cur_timeout);          // one past: everything clears
      send_packet(cur_guard, 32'd401 + cur_timeout);
      send_packet(stage_port[0], 32'hFFFF_FF00);
      send_packet(stage_port[1], 32'h0000_0010);             // tick counter wrapped
      send_packet(stage_port[2], 32'h0000_0020);
      send_packet(cur_guard, 32'h0000_0020);
      send_packet(stage_port[0], 32'h0000_0025 + cur_timeout); // timeout, then first knock
      send_packet(cur_guard, 32'h0000_0030 + cur_timeout);
      send_packet(16'hFFFF, 32'hFFFF_FFFF);
      tick_now = 32'd0;

      // Shortest sequence, zero timeout, extreme port values.
      apply_settings(16'h0000, 32'd0, 4'd1, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      run_phase(100);

      // Longest sequence with a timeout that never fires.
      apply_settings(16'hFFFF, 32'hFFFF_FFFF, 4'd8, {$urandom, $urandom},
                     {$urandom, $urandom});
      run_phase(60);

      // Length lowered below the progress already made, then a real timeout.
      apply_settings(any_port(), 32'hFFFF_FFFF, 4'd2,
                     {$urandom, $urandom}, {$urandom, $urandom});
      send_packet(stage_port[0], tick_now);
      send_packet(stage_port[1], tick_now);
      send_packet(cur_guard, tick_now);
      settle_gate();
      csr_write(pkgate_pkg::RegTimeoutTicks, 64'd500);
      cur_timeout = 32'd500;
      run_phase(100);

      // Length above the maximum; the receiver holds off while packets keep coming.
      apply_settings(any_port(), 32'($urandom_range(100, 5000)), 4'd15,
                     {$urandom, $urandom}, {$urandom, $urandom});
      tx_calm = 1'b1;
      rx_hold_req = 1'b1;
      run_phase(120);
      tx_calm = 1'b0;

      // Zero length register, one-tick timeout, receiver never stalls.
      apply_settings(any_port(), 32'd1, 4'd0, {$urandom, $urandom},
                     {$urandom, $urandom});
      rx_calm = 1'b1;
      run_phase(100);

      // No idling on either side.
      apply_settings(any_port(), 32'($urandom_range(1, 3000)),
                     4'($urandom_range(1, 8)), {$urandom, $urandom}, {$urandom, $urandom});
      tx_calm = 1'b1;
      run_phase(100);
      tx_calm = 1'b0;
      rx_calm = 1'b0;

      // Fully random settings; the guarded port sometimes doubles as a knock port.
      for (int p = 0; p < 3; p++) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         guard = ($urandom_range(0, 3) == 0) ? lo[15:0] : any_port();
         apply_settings(guard, 32'($urandom_range(1, 4000)), 4'($urandom_range(0, 15)),
                        lo, hi);
         run_phase(100);
      end

      settle_gate();
      repeat (10) @(negedge clock);
      if (mismatch_total == 0 && results_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
